// ===== design/swa_pkg.sv =====
// shared types and constants for the stopwatch with alarms
// no dependencies; imported by every module of the block
package swa_pkg;

	// field widths
	localparam int unsigned CMD_W     = 3;
	localparam int unsigned ALARM_W   = 31;
	localparam int unsigned MS_W      = 32;
	localparam int unsigned HOURS_W   = 11;
	localparam int unsigned MIN_W     = 6;
	localparam int unsigned SEC_W     = 6;
	localparam int unsigned SUBMS_W   = 10;
	localparam int unsigned FIRED_W   = 4;

	// time unit limits
	localparam int unsigned MS_PER_SEC  = 1000;
	localparam int unsigned SEC_PER_MIN = 60;
	localparam int unsigned MIN_PER_HR  = 60;

	// default alarm table depth
	localparam int unsigned ALARM_SLOTS_DEF = 4;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 3'd0,
		CMD_START  = 3'd1,
		CMD_STOP   = 3'd2,
		CMD_PAUSE  = 3'd3,
		CMD_RESUME = 3'd4,
		CMD_RESET  = 3'd5,
		CMD_ARM    = 3'd6
	} cmd_t;

	// command word
	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [ALARM_W-1:0] alarm_ms;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [MS_W-1:0]    elapsed_ms;
		logic [HOURS_W-1:0] hours;
		logic [MIN_W-1:0]   minutes;
		logic [SEC_W-1:0]   seconds;
		logic               is_running;
		logic               is_paused;
		logic [FIRED_W-1:0] alarms_fired;
		logic               arm_rejected;
	} out_word_t;

	// timer controls
	typedef struct packed {
		logic clear;
		logic incr;
	} tmr_ctl_t;

	// alarm table controls
	typedef struct packed {
		logic clear;
		logic arm;
	} alm_ctl_t;

endpackage

// ===== design/swa_timer.sv =====
// millisecond counter with an incrementally kept hours / minutes / seconds split
// depends on swa_pkg
module swa_timer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  swa_pkg::tmr_ctl_t         ctl,
	output logic [swa_pkg::MS_W-1:0]    ms,
	output logic [swa_pkg::HOURS_W-1:0] hours,
	output logic [swa_pkg::MIN_W-1:0]   minutes,
	output logic [swa_pkg::SEC_W-1:0]   seconds
);
	import swa_pkg::*;

	logic [MS_W-1:0]    ms_q;
	logic [SUBMS_W-1:0] subms_q;
	logic [SEC_W-1:0]   sec_q;
	logic [MIN_W-1:0]   min_q;
	logic [HOURS_W-1:0] hr_q;
	logic               step;
	logic               sec_wrap;
	logic               min_wrap;
	logic               hr_wrap;

	// count saturates at all ones, the split follows only real steps
	assign step     = ctl.incr && (ms_q != '1);
	assign sec_wrap = (subms_q == SUBMS_W'(MS_PER_SEC - 1));
	assign min_wrap = sec_wrap && (sec_q == SEC_W'(SEC_PER_MIN - 1));
	assign hr_wrap  = min_wrap && (min_q == MIN_W'(MIN_PER_HR - 1));

	// counter chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q    <= '0;
			subms_q <= '0;
			sec_q   <= '0;
			min_q   <= '0;
			hr_q    <= '0;
		end else if (ctl.clear) begin
			ms_q    <= '0;
			subms_q <= '0;
			sec_q   <= '0;
			min_q   <= '0;
			hr_q    <= '0;
		end else if (step) begin
			ms_q    <= ms_q + MS_W'(1);
			subms_q <= sec_wrap ? '0 : subms_q + SUBMS_W'(1);
			if (sec_wrap) begin
				sec_q <= min_wrap ? '0 : sec_q + SEC_W'(1);
			end
			if (min_wrap) begin
				min_q <= hr_wrap ? '0 : min_q + MIN_W'(1);
			end
			if (hr_wrap) begin
				hr_q <= hr_q + HOURS_W'(1);
			end
		end
	end

	assign ms      = ms_q;
	assign hours   = hr_q;
	assign minutes = min_q;
	assign seconds = sec_q;

endmodule

// ===== design/swa_alarms.sv =====
// alarm threshold table with parallel compare against the running count
// depends on swa_pkg
module swa_alarms #(
	parameter int unsigned ALARM_SLOTS = swa_pkg::ALARM_SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  swa_pkg::alm_ctl_t            ctl,
	input  logic [swa_pkg::ALARM_W-1:0]  alarm_ms,
	input  logic [swa_pkg::MS_W-1:0]     ms,
	output logic [swa_pkg::FIRED_W-1:0]  fired,
	output logic                         full
);
	import swa_pkg::*;

	localparam int unsigned CNT_W = $clog2(ALARM_SLOTS + 1);
	localparam int unsigned IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;

	logic [ALARM_W-1:0] thr_q [ALARM_SLOTS];
	logic [CNT_W-1:0]   count_q;

	assign full = (count_q == CNT_W'(ALARM_SLOTS));

	// fill count, cleared by reset command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clear) begin
			count_q <= '0;
		end else if (ctl.arm && !full) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// threshold storage, entries past the fill count are never looked at
	always_ff @(posedge clk) begin
		if (ctl.arm && !full && !ctl.clear) begin
			thr_q[count_q[IDX_W-1:0]] <= alarm_ms;
		end
	end

	// one comparator per slot, slots beyond the reported mask are dropped
	for (genvar i = 0; i < FIRED_W; i++) begin : g_fire
		if (i < ALARM_SLOTS) begin : g_slot
			assign fired[i] = (CNT_W'(i) < count_q) && (ms >= {1'b0, thr_q[i]});
		end else begin : g_none
			assign fired[i] = 1'b0;
		end
	end

endmodule

// ===== design/stopwatch_with_alarms_top.sv =====
// stopwatch with alarms: a command passes the input register, then the result register
// throughput one command word per cycle, stalls only while the result is held
// state is kept as counters, so the time split needs no divider
// arst_n clears flags, count, time split, alarm fill count and both valid bits
// alarm threshold entries are not cleared; only filled entries are compared
module stopwatch_with_alarms_top #(
	parameter int unsigned ALARM_SLOTS = swa_pkg::ALARM_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  swa_pkg::in_word_t  cmd_word,
	output logic               res_valid,
	input  logic               res_stall,
	output swa_pkg::out_word_t res_word
);
	import swa_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_PAUSE
	} state_t;

	state_t             state_q;
	state_t             state_nxt;
	logic               valid_s1;
	cmd_t               cmd_s1;
	logic [ALARM_W-1:0] alarm_s1;
	logic               res_valid_q;
	logic [FIRED_W-1:0] fired_q;
	logic               rejected_q;
	logic [FIRED_W-1:0] fired_nxt;
	logic               rejected_nxt;
	logic               fire;
	logic               accept;
	tmr_ctl_t           tctl;
	alm_ctl_t           actl;
	logic [MS_W-1:0]    ms;
	logic [HOURS_W-1:0] hours;
	logic [MIN_W-1:0]   minutes;
	logic [SEC_W-1:0]   seconds;
	logic [FIRED_W-1:0] fired;
	logic               full;

	// handshake: the held word moves on when the result slot is free
	assign fire      = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = valid_s1 && !fire;
	assign accept    = cmd_valid && !cmd_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= cmd_t'(cmd_word.command);
			alarm_s1 <= cmd_word.alarm_ms;
		end
	end

	// command decode
	always_comb begin
		state_nxt    = state_q;
		tctl         = '0;
		actl         = '0;
		fired_nxt    = '0;
		rejected_nxt = 1'b0;
		if (fire) begin
			case (cmd_s1)
				CMD_TICK: begin
					tctl.incr = (state_q == ST_RUN);
				end
				CMD_START: begin
					if (state_q == ST_IDLE) begin
						tctl.clear = 1'b1;
						state_nxt  = ST_RUN;
					end
				end
				CMD_STOP: begin
					if (state_q == ST_RUN) begin
						state_nxt = ST_IDLE;
						fired_nxt = fired;
					end
				end
				CMD_PAUSE: begin
					if (state_q == ST_RUN) begin
						state_nxt = ST_PAUSE;
					end
				end
				CMD_RESUME: begin
					if (state_q == ST_PAUSE) begin
						state_nxt = ST_RUN;
					end
				end
				CMD_RESET: begin
					tctl.clear = 1'b1;
					actl.clear = 1'b1;
					state_nxt  = ST_IDLE;
				end
				CMD_ARM: begin
					if (full) begin
						rejected_nxt = 1'b1;
					end else begin
						actl.arm = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// run state and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			fired_q     <= '0;
			rejected_q  <= 1'b0;
		end else begin
			if (fire) begin
				state_q     <= state_nxt;
				res_valid_q <= 1'b1;
				fired_q     <= fired_nxt;
				rejected_q  <= rejected_nxt;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	swa_timer u_timer (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tctl),
		.ms      (ms),
		.hours   (hours),
		.minutes (minutes),
		.seconds (seconds)
	);

	swa_alarms #(
		.ALARM_SLOTS (ALARM_SLOTS)
	) u_alarms (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (actl),
		.alarm_ms (alarm_s1),
		.ms       (ms),
		.fired    (fired),
		.full     (full)
	);

	// result word comes straight from state, which only moves with a new result
	assign res_valid               = res_valid_q;
	assign res_word.elapsed_ms     = ms;
	assign res_word.hours          = hours;
	assign res_word.minutes        = minutes;
	assign res_word.seconds        = seconds;
	assign res_word.is_running     = (state_q != ST_IDLE);
	assign res_word.is_paused      = (state_q == ST_PAUSE);
	assign res_word.alarms_fired   = fired_q;
	assign res_word.arm_rejected   = rejected_q;

`ifndef SYNTHESIS
	// input side stalls only because a result is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (res_valid_q && res_stall))
		else $error("command stall without held result");

	// a tick never lowers the count
	a_tick_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (cmd_s1 == CMD_TICK)) |=> (ms >= $past(ms)))
		else $error("tick decreased count");

	// time split stays in range
	a_split_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((res_word.minutes < MIN_W'(MIN_PER_HR))
			&& (res_word.seconds < SEC_W'(SEC_PER_MIN))))
		else $error("time split out of range");

	// a reject and a fired mask never come from the same command
	a_excl_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_word.arm_rejected && (res_word.alarms_fired != '0)))
		else $error("reject and fired mask together");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench for stopwatch_with_alarms_top: commands in, status words out
// depends on swa_pkg and the top-level RTL only; predicts every status word on accept

module testbench;
	import swa_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 200000;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned SLOTS        = ALARM_SLOTS_DEF;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

	// tracks stopwatch state and holds the status words still due from the block
	class stopwatch_scoreboard;
		out_word_t        status_due[$];
		int unsigned      errors;
		bit               running;
		bit               paused;
		bit [MS_W-1:0]    count_ms;
		bit [ALARM_W-1:0] thresholds[SLOTS];
		int unsigned      armed;

		// advance the stopwatch by one accepted command word, queue its status
		function void note_command(in_word_t w);
			out_word_t   st;
			int unsigned secs;
			int unsigned i;
			st = '0;
			case (w.command)
				CMD_TICK: begin
					if (running && !paused && count_ms != '1)
						count_ms++;
				end
				CMD_START: begin
					if (!running) begin
						count_ms = '0;
						running  = 1'b1;
						paused   = 1'b0;
					end
				end
				CMD_STOP: begin
					if (running && !paused) begin
						running = 1'b0;
						for (i = 0; i < armed && i < FIRED_W; i++)
							if (count_ms >= thresholds[i])
								st.alarms_fired[i] = 1'b1;
					end
				end
				CMD_PAUSE: begin
					if (running && !paused)
						paused = 1'b1;
				end
				CMD_RESUME: begin
					if (running && paused)
						paused = 1'b0;
				end
				CMD_RESET: begin
					running  = 1'b0;
					paused   = 1'b0;
					count_ms = '0;
					armed    = 0;
				end
				CMD_ARM: begin
					if (armed < SLOTS) begin
						thresholds[armed] = w.alarm_ms;
						armed++;
					end else begin
						st.arm_rejected = 1'b1;
					end
				end
				default: ;
			endcase
			// time split of the count
			secs          = count_ms / MS_PER_SEC;
			st.elapsed_ms = count_ms;
			st.hours      = HOURS_W'(secs / (SEC_PER_MIN * MIN_PER_HR));
			st.minutes    = MIN_W'((secs / SEC_PER_MIN) % MIN_PER_HR);
			st.seconds    = SEC_W'(secs % SEC_PER_MIN);
			st.is_running = running;
			st.is_paused  = paused;
			status_due.insert(status_due.size(), st);
		endfunction

		function void compare_field(string name, logic [MS_W-1:0] exp_v,
				logic [MS_W-1:0] act_v);
			if (act_v !== exp_v) begin
				errors++;
				$display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
			end
		endfunction

		// compare one accepted status word against the oldest one due
		function void check_status(out_word_t act);
			out_word_t exp_w;
			if (status_due.size() == 0) begin
				errors++;
				$display("%0t: status word with none due, expected none actual %h",
					$time, act);
				return;
			end
			exp_w = status_due.pop_front();
			compare_field("elapsed_ms", exp_w.elapsed_ms, act.elapsed_ms);
			compare_field("hours", MS_W'(exp_w.hours), MS_W'(act.hours));
			compare_field("minutes", MS_W'(exp_w.minutes), MS_W'(act.minutes));
			compare_field("seconds", MS_W'(exp_w.seconds), MS_W'(act.seconds));
			compare_field("is_running", MS_W'(exp_w.is_running), MS_W'(act.is_running));
			compare_field("is_paused", MS_W'(exp_w.is_paused), MS_W'(act.is_paused));
			compare_field("alarms_fired", MS_W'(exp_w.alarms_fired),
				MS_W'(act.alarms_fired));
			compare_field("arm_rejected", MS_W'(exp_w.arm_rejected),
				MS_W'(act.arm_rejected));
		endfunction

		// words never delivered count as failures
		function int unsigned final_errors();
			if (status_due.size() != 0) begin
				errors++;
				$display("%0t: status words left over, expected 0 actual %0d",
					$time, status_due.size());
			end
			return errors;
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	in_word_t  cmd_word;
	logic      res_valid;
	logic      res_stall;
	out_word_t res_word;

	stopwatch_scoreboard sb = new();

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned words_sent;
	int unsigned cycle_count;

	stopwatch_with_alarms_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_word  (cmd_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// drive one command word, with random idle cycles in front
	task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [ALARM_W-1:0] ms);
		in_word_t w;
		w.command  = c;
		w.alarm_ms = ms;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_word  <= w;
		do
			@(posedge clk);
		while (cmd_stall);
		sb.note_command(w);
		words_sent++;
	endtask

	function automatic logic [ALARM_W-1:0] rand_ms();
		return ALARM_W'($urandom());
	endfunction

	// thresholds mostly in reach of a short run, some never reached
	function automatic logic [ALARM_W-1:0] pick_threshold();
		int unsigned k;
		k = $urandom_range(9);
		if (k == 0)
			return '0;
		if (k == 1)
			return rand_ms();
		return ALARM_W'($urandom_range(200));
	endfunction

	task automatic send_ticks(input int unsigned n);
		repeat (n) send_cmd(CMD_TICK, rand_ms());
	endtask

	// edge cases: commands in the wrong state, table full, stop with alarms
	task automatic directed_cmds();
		send_cmd(CMD_RESET, '1);
		send_cmd(CMD_TICK, '0);
		send_cmd(CMD_STOP, '1);
		send_cmd(CMD_PAUSE, '0);
		send_cmd(CMD_RESUME, '1);
		send_cmd(CMD_ARM, '0);
		send_cmd(CMD_ARM, 31'd3);
		send_cmd(CMD_ARM, 31'd5);
		send_cmd(CMD_ARM, '1);
		send_cmd(CMD_ARM, '1);
		send_cmd(CMD_START, '0);
		send_ticks(4);
		send_cmd(CMD_START, '1);
		send_cmd(CMD_PAUSE, '0);
		send_cmd(CMD_TICK, '1);
		send_cmd(CMD_PAUSE, '1);
		send_cmd(CMD_STOP, '0);
		send_cmd(CMD_RESUME, '1);
		send_cmd(CMD_RESUME, '0);
		send_cmd(CMD_TICK, '0);
		send_cmd(CMD_STOP, '1);
		send_cmd(CMD_UNUSED, '1);
		send_cmd(CMD_START, '0);
		send_cmd(CMD_STOP, '0);
	endtask

	// arm, start, run with pauses and noise, then usually stop
	task automatic run_session(input int unsigned long_run);
		int unsigned k;
		if ($urandom_range(3) == 0)
			send_cmd(CMD_RESET, rand_ms());
		repeat ($urandom_range(5)) send_cmd(CMD_ARM, pick_threshold());
		send_cmd(CMD_START, rand_ms());
		send_ticks(long_run);
		repeat ($urandom_range(12, 1)) begin
			k = $urandom_range(99);
			if (k < 55) begin
				send_ticks($urandom_range(40, 1));
			end else if (k < 72) begin
				send_cmd(CMD_PAUSE, rand_ms());
				send_ticks($urandom_range(2));
				if ($urandom_range(5) != 0)
					send_cmd(CMD_RESUME, rand_ms());
			end else if (k < 80) begin
				send_cmd(CMD_ARM, pick_threshold());
			end else begin
				send_cmd(CMD_W'($urandom_range(7)), rand_ms());
			end
		end
		if ($urandom_range(9) != 0)
			send_cmd(CMD_STOP, rand_ms());
	endtask

	// result side: check accepted words, pick the next stall
	initial begin
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !res_stall)
				sb.check_status(res_word);
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int unsigned quota;
		int unsigned phase;
		int unsigned long_run;
		cmd_valid     <= 1'b0;
		cmd_word      <= '0;
		arst_n        <= 1'b0;
		send_idle_pct = 8;
		recv_idle_pct = 58;
		words_sent    = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// three idling phases, the last one with none
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 8;  recv_idle_pct = 58; end
				1: begin send_idle_pct = 58; recv_idle_pct = 8;  end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			if (phase == 0)
				directed_cmds();
			quota = words_sent + ((phase == 2) ? 1100 : 200);
			// the first session of the last phase may be a long run that crosses a seconds boundary
			long_run = (phase == 2) ? $urandom_range(1100, 1010) : 0;
			while (words_sent < quota) begin
				if ($urandom_range(4) == 0)
					repeat ($urandom_range(6, 1))
						send_cmd(CMD_W'($urandom_range(7)), rand_ms());
				else
					run_session(long_run);
				long_run = 0;
			end
		end
		cmd_valid <= 1'b0;

		while (sb.status_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.final_errors() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
